/* hdl/tlpt_pkg.sv */
// Shared types and constants of the two-level page table mapper.
// No dependencies; every other source file but tlpt_if.sv refers to this package.
package tlpt_pkg;

   // Default number of 4 KiB pages in the word store.
   localparam int STORE_PAGES_DEF = 256;
   // Words in one page and width of the in-page word index.
   localparam int WORDS_PER_PAGE = 1024;
   localparam int ENTRY_IDX_W = 10;
   // Width of the page frame number carried by entries and addresses.
   localparam int FRAME_NUM_W = 20;
   // Allocator start frame after reset.
   localparam logic [7:0] FIRST_FREE_RESET = 8'd64;

   // Configuration port geometry: one register, byte addressed with the low two bits ignored.
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_FIRST_FREE = 1'b0;

   typedef enum logic [1:0] {
      CMD_MAP   = 2'd0,
      CMD_UNMAP = 2'd1,
      CMD_READ  = 2'd2,
      CMD_WRITE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_MISALIGNED = 3'd1,
      STAT_OUTSIDE    = 3'd2,
      STAT_NO_FRAME   = 3'd3,
      STAT_NOT_MAPPED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ISSUE,
      S_WALK,
      S_READ,
      S_TABLE,
      S_DONE
   } state_type;

   // Configuration handed from the register block to the controller.
   typedef struct packed {
      logic       load;
      logic [7:0] first_free;
   } cfg_type;

   // One result transaction.
   typedef struct packed {
      status_type                 status;
      logic [31:0]                read_data;
      logic                       table_allocated;
      logic [FRAME_NUM_W-1:0]     table_frame;
   } rsp_payload_type;

endpackage

/* hdl/tlpt_if.sv */
// Request and response channel interfaces of the page table mapper.
// Depends on nothing but plain logic types; widths follow the field list.
interface tlpt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] virt_addr;
   logic [31:0] dir_base;
   logic [31:0] phys_addr;
   logic        user_access;
   logic [17:0] word_addr;
   logic [31:0] write_data;

   modport source (output valid, command, virt_addr, dir_base, phys_addr, user_access,
                   word_addr, write_data, input ready);
   modport sink (input valid, command, virt_addr, dir_base, phys_addr, user_access,
                 word_addr, write_data, output ready);
endinterface

interface tlpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] read_data;
   logic        table_allocated;
   logic [19:0] table_frame;

   modport source (output valid, status, read_data, table_allocated, table_frame,
                   input ready);
   modport sink (input valid, status, read_data, table_allocated, table_frame,
                 output ready);
endinterface

/* hdl/tlpt_store.sv */
// Word store of the mapper: single-port synchronous RAM with a registered read.
// Depends on tlpt_pkg for the page geometry.
module tlpt_store #(
   parameter int STORE_PAGES = tlpt_pkg::STORE_PAGES_DEF
) (
   input  logic                 clock,
   input  logic                 mem_en,
   input  logic                 mem_we,
   input  logic [$clog2(STORE_PAGES)+tlpt_pkg::ENTRY_IDX_W-1:0] mem_addr,
   input  logic [31:0]          mem_wdata,
   output logic [31:0]          mem_rdata
);

   localparam int DEPTH = STORE_PAGES * tlpt_pkg::WORDS_PER_PAGE;

   logic [31:0] store_ff [0:DEPTH-1];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            store_ff[mem_addr] <= mem_wdata;
         end else begin
            rdata_ff <= store_ff[mem_addr];
         end
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

/* hdl/tlpt_csr.sv */
// Configuration register block: holds first_free_frame behind an APB-style port.
// Depends on tlpt_pkg for the register map and the cfg_type struct.
module tlpt_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tlpt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output tlpt_pkg::cfg_type               cfg
);

   logic [7:0] first_free_ff;
   logic [7:0] first_free_in;
   logic       reg_hit;
   logic       wr_fire;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[tlpt_pkg::CSR_ADDR_W-1:2] == tlpt_pkg::REG_FIRST_FREE);
   assign wr_fire = psel && penable && pwrite && pready && reg_hit;

   always_comb begin
      first_free_in = first_free_ff;
      if (wr_fire) begin
         first_free_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_free_ff <= tlpt_pkg::FIRST_FREE_RESET;
      end else begin
         first_free_ff <= first_free_in;
      end
   end

   assign prdata         = reg_hit ? {24'd0, first_free_ff} : 32'd0;
   assign cfg.load       = wr_fire;
   assign cfg.first_free = pwdata[7:0];

endmodule

/* hdl/tlpt_ctrl.sv */
// Command sequencer of the mapper: clears the store, walks directory and
// table entries, runs the frame allocator and holds the result register.
// Depends on tlpt_pkg and on the channel interfaces in tlpt_if.sv.
module tlpt_ctrl #(
   parameter int STORE_PAGES = tlpt_pkg::STORE_PAGES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tlpt_pkg::cfg_type    cfg,
   tlpt_req_if.sink             req_chan,
   tlpt_rsp_if.source           rsp_chan,
   output logic                 mem_en,
   output logic                 mem_we,
   output logic [$clog2(STORE_PAGES)+tlpt_pkg::ENTRY_IDX_W-1:0] mem_addr,
   output logic [31:0]          mem_wdata,
   input  logic [31:0]          mem_rdata
);

   localparam int FRAME_W = $clog2(STORE_PAGES);
   localparam int ADDR_W  = FRAME_W + tlpt_pkg::ENTRY_IDX_W;
   localparam int DEPTH   = STORE_PAGES * tlpt_pkg::WORDS_PER_PAGE;
   localparam int FN_W    = tlpt_pkg::FRAME_NUM_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(DEPTH - 1);
   localparam logic [FN_W-1:0]   PAGES_LIMIT = FN_W'(STORE_PAGES);
   localparam logic [31:0]       WORD_LIMIT  = 32'(DEPTH);

   tlpt_pkg::state_type       state_ff, state_in;
   logic [ADDR_W-1:0]         clr_addr_ff, clr_addr_in;
   logic [FN_W-1:0]           next_free_ff, next_free_in;
   logic [FN_W-1:0]           tab_frame_ff, tab_frame_in;
   tlpt_pkg::rsp_payload_type res_ff, res_in;
   tlpt_pkg::rsp_payload_type out_ff, out_in;
   logic                      out_valid_ff, out_valid_in;

   // Latched request.
   tlpt_pkg::cmd_type cmd_ff;
   logic [31:0]       va_ff, dbase_ff, pa_ff, wdata_ff;
   logic              user_ff;
   logic [17:0]       waddr_ff;

   logic              accept;
   logic              out_free;
   logic              is_word_cmd;
   logic [31:0]       word_ext;
   logic              word_ok;
   logic [FN_W-1:0]   dir_frame;
   logic              dir_ok;
   logic              misaligned;
   logic              pde_present;
   logic [FN_W-1:0]   pde_frame;
   logic              pde_ok;
   logic              free_ok;
   logic [31:0]       pte;
   logic [ADDR_W-1:0] dir_addr;
   logic [tlpt_pkg::ENTRY_IDX_W-1:0] tab_idx;

   assign accept      = (state_ff == tlpt_pkg::S_IDLE) && req_chan.valid;
   assign out_free    = !out_valid_ff || rsp_chan.ready;
   assign is_word_cmd = (cmd_ff == tlpt_pkg::CMD_READ) || (cmd_ff == tlpt_pkg::CMD_WRITE);
   assign word_ext    = 32'(waddr_ff);
   assign word_ok     = word_ext < WORD_LIMIT;
   assign dir_frame   = dbase_ff[31:12];
   assign dir_ok      = dir_frame < PAGES_LIMIT;
   assign misaligned  = (va_ff[11:0] != 12'd0) ||
                        ((cmd_ff == tlpt_pkg::CMD_MAP) && (pa_ff[11:0] != 12'd0));
   assign pde_present = mem_rdata[0];
   assign pde_frame   = mem_rdata[31:12];
   assign pde_ok      = pde_frame < PAGES_LIMIT;
   assign free_ok     = next_free_ff < PAGES_LIMIT;
   assign pte         = {pa_ff[31:12], 9'd0, user_ff, 2'b11};
   assign tab_idx     = va_ff[21:12];
   assign dir_addr    = {dir_frame[FRAME_W-1:0], va_ff[31:22]};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlpt_pkg::S_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = tlpt_pkg::S_IDLE;
            end
         end
         tlpt_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               state_in = tlpt_pkg::S_ISSUE;
            end
         end
         tlpt_pkg::S_ISSUE: begin
            if (is_word_cmd) begin
               if (word_ok && (cmd_ff == tlpt_pkg::CMD_READ)) begin
                  state_in = tlpt_pkg::S_READ;
               end else begin
                  state_in = tlpt_pkg::S_DONE;
               end
            end else if (misaligned || !dir_ok) begin
               state_in = tlpt_pkg::S_DONE;
            end else begin
               state_in = tlpt_pkg::S_WALK;
            end
         end
         tlpt_pkg::S_WALK: begin
            if (!pde_present && (cmd_ff == tlpt_pkg::CMD_MAP) && free_ok) begin
               state_in = tlpt_pkg::S_TABLE;
            end else begin
               state_in = tlpt_pkg::S_DONE;
            end
         end
         tlpt_pkg::S_READ: begin
            state_in = tlpt_pkg::S_DONE;
         end
         tlpt_pkg::S_TABLE: begin
            state_in = tlpt_pkg::S_DONE;
         end
         tlpt_pkg::S_DONE: begin
            if (out_free) begin
               state_in = tlpt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tlpt_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs: memory port, result, allocator and output register.
   always_comb begin
      mem_en       = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = '0;
      mem_wdata    = 32'd0;
      clr_addr_in  = clr_addr_ff;
      next_free_in = next_free_ff;
      tab_frame_in = tab_frame_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      req_chan.ready = (state_ff == tlpt_pkg::S_IDLE);

      case (state_ff)
         tlpt_pkg::S_CLEAR: begin
            mem_en      = 1'b1;
            mem_we      = 1'b1;
            mem_addr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         tlpt_pkg::S_ISSUE: begin
            res_in.status          = tlpt_pkg::STAT_OK;
            res_in.read_data       = 32'd0;
            res_in.table_allocated = 1'b0;
            res_in.table_frame     = '0;
            if (is_word_cmd) begin
               if (!word_ok) begin
                  res_in.status = tlpt_pkg::STAT_OUTSIDE;
               end else begin
                  mem_en    = 1'b1;
                  mem_we    = (cmd_ff == tlpt_pkg::CMD_WRITE);
                  mem_addr  = word_ext[ADDR_W-1:0];
                  mem_wdata = wdata_ff;
               end
            end else if (misaligned) begin
               res_in.status = tlpt_pkg::STAT_MISALIGNED;
            end else if (!dir_ok) begin
               res_in.status = tlpt_pkg::STAT_OUTSIDE;
            end else begin
               mem_en   = 1'b1;
               mem_addr = dir_addr;
            end
         end
         tlpt_pkg::S_READ: begin
            res_in.read_data = mem_rdata;
         end
         tlpt_pkg::S_WALK: begin
            if (pde_present) begin
               if (!pde_ok) begin
                  res_in.status = tlpt_pkg::STAT_OUTSIDE;
               end else begin
                  // Existing table: write or clear the table entry now.
                  mem_en             = 1'b1;
                  mem_we             = 1'b1;
                  mem_addr           = {pde_frame[FRAME_W-1:0], tab_idx};
                  mem_wdata          = (cmd_ff == tlpt_pkg::CMD_MAP) ? pte : 32'd0;
                  res_in.table_frame = pde_frame;
                  res_in.read_data   = (cmd_ff == tlpt_pkg::CMD_MAP) ? pte : 32'd0;
               end
            end else if (cmd_ff == tlpt_pkg::CMD_UNMAP) begin
               res_in.status = tlpt_pkg::STAT_NOT_MAPPED;
            end else if (!free_ok) begin
               res_in.status = tlpt_pkg::STAT_NO_FRAME;
            end else begin
               // Take a table page and point the directory entry at it.
               mem_en                 = 1'b1;
               mem_we                 = 1'b1;
               mem_addr               = dir_addr;
               mem_wdata              = {next_free_ff, 9'd0, user_ff, 2'b11};
               next_free_in           = next_free_ff + 1'b1;
               tab_frame_in           = next_free_ff;
               res_in.table_allocated = 1'b1;
               res_in.table_frame     = next_free_ff;
               res_in.read_data       = pte;
            end
         end
         tlpt_pkg::S_TABLE: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = {tab_frame_ff[FRAME_W-1:0], tab_idx};
            mem_wdata = pte;
         end
         default: begin
         end
      endcase

      if (cfg.load) begin
         next_free_in = FN_W'(cfg.first_free);
      end

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if ((state_ff == tlpt_pkg::S_DONE) && out_free) begin
         out_valid_in = 1'b1;
         out_in       = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlpt_pkg::S_CLEAR;
         clr_addr_ff  <= '0;
         next_free_ff <= FN_W'(tlpt_pkg::FIRST_FREE_RESET);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         next_free_ff <= next_free_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tab_frame_ff <= tab_frame_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
      if (accept) begin
         cmd_ff   <= tlpt_pkg::cmd_type'(req_chan.command);
         va_ff    <= req_chan.virt_addr;
         dbase_ff <= req_chan.dir_base;
         pa_ff    <= req_chan.phys_addr;
         user_ff  <= req_chan.user_access;
         waddr_ff <= req_chan.word_addr;
         wdata_ff <= req_chan.write_data;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.status          = out_ff.status;
   assign rsp_chan.read_data       = out_ff.read_data;
   assign rsp_chan.table_allocated = out_ff.table_allocated;
   assign rsp_chan.table_frame     = out_ff.table_frame;

endmodule

/* hdl/two_level_page_table_mapper.sv */
// Top level of the two-level page table mapper.
// Depends on tlpt_pkg, tlpt_if.sv, tlpt_csr, tlpt_ctrl and tlpt_store.
//
// Usage: the block owns a word store of STORE_PAGES pages of 1024 words that
// holds x86-style page directory and page table entries. Each request
// transaction on req_chan carries one command (map, unmap, read word, write
// word); each one yields exactly one response transaction on rsp_chan with a
// status, the word read or table entry written, an allocation flag and the
// table frame used. Both channels use valid/ready handshakes.
// The APB-style port holds first_free_frame; writing it also reloads the
// table page allocator. Write it only while no transaction is in flight.
// After reset the block sweeps the whole store to zero, one word per clock;
// req_chan.ready stays low until the sweep is done, while configuration
// writes are taken throughout.
// Transactions are handled one at a time through the single-port store.
// A map that allocates a table page makes a directory read, a directory
// write and a table write, each in its own access to the one store port.
// The response sits in an output register; a stalled receiver holds the
// sequencer in its final step.
module two_level_page_table_mapper #(
   parameter int STORE_PAGES = tlpt_pkg::STORE_PAGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tlpt_req_if.sink                        req_chan,
   tlpt_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tlpt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int ADDR_W = $clog2(STORE_PAGES) + tlpt_pkg::ENTRY_IDX_W;

   tlpt_pkg::cfg_type cfg;
   logic              mem_en;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [31:0]       mem_wdata;
   logic [31:0]       mem_rdata;

   // Register block: first_free_frame and the allocator reload strobe.
   tlpt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer: clearing sweep, table walk, allocator and response register.
   tlpt_ctrl #(
      .STORE_PAGES (STORE_PAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // The page store itself.
   tlpt_store #(
      .STORE_PAGES (STORE_PAGES)
   ) u_store (
      .clock     (clock),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the two-level page table mapper.
// Uses tlpt_pkg, the channel interfaces in tlpt_if.sv and the block itself;
// it keeps a shadow of the word store and predicts every response.
module tb_top;

   // The block runs at its default size, so every 18-bit word index lies
   // inside the store and the out-of-store read/write case cannot occur.
   localparam int STORE_PAGES = tlpt_pkg::STORE_PAGES_DEF;
   localparam int STORE_WORDS = STORE_PAGES * tlpt_pkg::WORDS_PER_PAGE;

   // Entry flag bits of directory and table entries.
   localparam logic [31:0] ENTRY_PRESENT  = 32'h0000_0001;
   localparam logic [31:0] ENTRY_WRITABLE = 32'h0000_0002;
   localparam logic [31:0] ENTRY_USER     = 32'h0000_0004;

   // Random part: one allocator setting per phase.
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 305;
   localparam logic [7:0] FIRST_FREE_PLAN [PHASES] = '{8'd255, 8'd0, 8'd0, 8'd250, 8'd64, 8'd1};
   // Phase 2 draws its allocator start at random instead of taking the plan.
   localparam int RANDOM_PHASE    = 2;

   localparam int DRAIN_CYCLES    = 12;
   // The limit exceeds the clearing sweep plus the slowest correct run of the items.
   localparam int RUN_LIMIT       = 4_800_000;

   // One request transaction, in the order of the channel's fields.
   typedef struct packed {
      tlpt_pkg::cmd_type command;
      logic [31:0]       virt_addr;
      logic [31:0]       dir_base;
      logic [31:0]       phys_addr;
      logic              user_access;
      logic [17:0]       word_addr;
      logic [31:0]       write_data;
   } req_txn_type;

   // A directed row carries its response written out when it is plain to see;
   // otherwise the predictor supplies it.
   typedef struct packed {
      req_txn_type               txn;
      logic                      listed;
      tlpt_pkg::rsp_payload_type outcome;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 27;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // The clearing sweep leaves zero at both ends of the store.
      '{'{tlpt_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0000_0000, 1'b0, 20'd0}},
      '{'{tlpt_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          18'h3FFFF, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0000_0000, 1'b0, 20'd0}},
      // The last word takes all ones and gives them back, then is cleared again.
      '{'{tlpt_pkg::CMD_WRITE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          18'h3FFFF, 32'hFFFF_FFFF},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0000_0000, 1'b0, 20'd0}},
      '{'{tlpt_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          18'h3FFFF, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'hFFFF_FFFF, 1'b0, 20'd0}},
      '{'{tlpt_pkg::CMD_WRITE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          18'h3FFFF, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0000_0000, 1'b0, 20'd0}},
      // Unmap through an absent directory entry reports not mapped.
      '{'{tlpt_pkg::CMD_UNMAP, 32'h0040_0000, 32'h0000_1ABC, 32'h0000_0000, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_NOT_MAPPED, 32'h0000_0000, 1'b0, 20'd0}},
      // The first map allocates the table at the reset start frame; the
      // low bits of the directory base are ignored.
      '{'{tlpt_pkg::CMD_MAP,   32'h0040_0000, 32'h0000_1FFF, 32'hFFFF_F000, 1'b1,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'hFFFF_F007, 1'b1, 20'd64}},
      // A second map through the same directory entry reuses the table.
      '{'{tlpt_pkg::CMD_MAP,   32'h0040_1000, 32'h0000_1000, 32'h0000_0000, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0000_0003, 1'b0, 20'd64}},
      // The new directory entry and table entry as they sit in the store.
      '{'{tlpt_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          18'h00401, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0004_0007, 1'b0, 20'd0}},
      '{'{tlpt_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          18'h10000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'hFFFF_F007, 1'b0, 20'd0}},
      // Unmap ignores a misaligned physical address.
      '{'{tlpt_pkg::CMD_UNMAP, 32'h0040_0000, 32'h0000_1000, 32'h0000_0123, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0000_0000, 1'b0, 20'd64}},
      // Unmap of an entry that is already clear still succeeds.
      '{'{tlpt_pkg::CMD_UNMAP, 32'h0040_0000, 32'h0000_1000, 32'h0000_0000, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0000_0000, 1'b0, 20'd64}},
      '{'{tlpt_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          18'h10000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0000_0000, 1'b0, 20'd0}},
      // Misaligned virtual address, then misaligned physical address.
      '{'{tlpt_pkg::CMD_MAP,   32'h0000_0123, 32'h0000_1000, 32'h0000_0000, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_MISALIGNED, 32'h0000_0000, 1'b0, 20'd0}},
      '{'{tlpt_pkg::CMD_MAP,   32'h0000_0000, 32'h0000_1000, 32'h0000_0FFF, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_MISALIGNED, 32'h0000_0000, 1'b0, 20'd0}},
      // Alignment is checked ahead of the directory bounds.
      '{'{tlpt_pkg::CMD_UNMAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_MISALIGNED, 32'h0000_0000, 1'b0, 20'd0}},
      // Directory frames at the top of the range and just past the store.
      '{'{tlpt_pkg::CMD_MAP,   32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OUTSIDE, 32'h0000_0000, 1'b0, 20'd0}},
      '{'{tlpt_pkg::CMD_MAP,   32'h0000_0000, 32'h0010_0000, 32'h0000_0000, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OUTSIDE, 32'h0000_0000, 1'b0, 20'd0}},
      // The last directory frame and the last entries of every index.
      '{'{tlpt_pkg::CMD_MAP,   32'hFFFF_F000, 32'h000F_F000, 32'hFFFF_F000, 1'b1,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'hFFFF_F007, 1'b1, 20'd65}},
      // A present directory entry that points past the store.
      '{'{tlpt_pkg::CMD_WRITE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          18'h00402, 32'h0010_0001},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0000_0000, 1'b0, 20'd0}},
      '{'{tlpt_pkg::CMD_MAP,   32'h0080_0000, 32'h0000_1000, 32'h0000_5000, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OUTSIDE, 32'h0000_0000, 1'b0, 20'd0}},
      '{'{tlpt_pkg::CMD_UNMAP, 32'h0080_0000, 32'h0000_1000, 32'h0000_0000, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OUTSIDE, 32'h0000_0000, 1'b0, 20'd0}},
      // An absent directory entry full of junk is overwritten by the allocation.
      '{'{tlpt_pkg::CMD_WRITE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          18'h00403, 32'hFFFF_FFFE},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0000_0000, 1'b0, 20'd0}},
      '{'{tlpt_pkg::CMD_MAP,   32'h00C0_0000, 32'h0000_1000, 32'hA5A5_A000, 1'b0,
          18'h00000, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'hA5A5_A003, 1'b1, 20'd66}},
      '{'{tlpt_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          18'h00403, 32'h0000_0000},
        1'b1, '{tlpt_pkg::STAT_OK, 32'h0004_2003, 1'b0, 20'd0}},
      // Mixed bit patterns, left to the predictor.
      '{'{tlpt_pkg::CMD_MAP,   32'h5A5A_5000, 32'h0000_2000, 32'h3C3C_3000, 1'b1,
          18'h2AAAA, 32'h5555_AAAA},
        1'b0, '{tlpt_pkg::STAT_OK, 32'h0000_0000, 1'b0, 20'd0}},
      '{'{tlpt_pkg::CMD_UNMAP, 32'h5A5A_5000, 32'h0000_2000, 32'hC3C3_C000, 1'b0,
          18'h15555, 32'hAAAA_5555},
        1'b0, '{tlpt_pkg::STAT_OK, 32'h0000_0000, 1'b0, 20'd0}}
   };

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [tlpt_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   tlpt_req_if req_chan ();
   tlpt_rsp_if rsp_chan ();

   two_level_page_table_mapper u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Shadow of the block: the word store and the allocator pointer. Reset is
   // applied only once, so the shadow starts out as the all-zero store that
   // the clearing sweep leaves.
   bit   [31:0] store_image [STORE_WORDS];
   logic [19:0] alloc_next = 20'd64;

   // Responses owed by the block, oldest first.
   tlpt_pkg::rsp_payload_type outcomes_due [$];

   int fault_count = 0;
   // While set, neither side inserts idle cycles.
   bit steady = 1'b0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Counts a mismatch and prints one line for it.
   task automatic report_fault(input string what);
      fault_count++;
      $display("tb_top: mismatch at %0t: %s", $time, what);
   endtask

   // Idle cycles before the next transaction or between ready windows: most
   // gaps are short, a few are long, and none at all in steady stretches.
   function automatic int idle_span();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 96) return $urandom_range(4, 9);
      else return $urandom_range(10, 20);
   endfunction

   // Predicts the response of one transaction and applies its side effects
   // to the shadow store and the allocator, in the block's order of checks:
   // alignment, then store bounds, then the allocator.
   function automatic tlpt_pkg::rsp_payload_type page_walk_outcome(input req_txn_type t);
      tlpt_pkg::rsp_payload_type outcome;
      logic [19:0]     dir_frame;
      logic [19:0]     tab_frame;
      logic [31:0]     dir_entry;
      logic [31:0]     flags;
      int              dir_word;
      int              tab_word;
      bit              fresh_table;
      outcome = '0;
      outcome.status = tlpt_pkg::STAT_OK;
      dir_frame = t.dir_base[31:12];
      flags = ENTRY_PRESENT | ENTRY_WRITABLE | (t.user_access ? ENTRY_USER : 32'h0);
      fresh_table = 1'b0;

      if (t.command == tlpt_pkg::CMD_READ || t.command == tlpt_pkg::CMD_WRITE) begin
         if (t.word_addr >= STORE_WORDS) begin
            outcome.status = tlpt_pkg::STAT_OUTSIDE;
         end else if (t.command == tlpt_pkg::CMD_WRITE) begin
            store_image[t.word_addr] = t.write_data;
         end else begin
            outcome.read_data = store_image[t.word_addr];
         end
         return outcome;
      end

      if (t.virt_addr[11:0] != 12'h000 ||
          (t.command == tlpt_pkg::CMD_MAP && t.phys_addr[11:0] != 12'h000)) begin
         outcome.status = tlpt_pkg::STAT_MISALIGNED;
         return outcome;
      end
      if (dir_frame >= STORE_PAGES) begin
         outcome.status = tlpt_pkg::STAT_OUTSIDE;
         return outcome;
      end

      dir_word = int'(dir_frame) * tlpt_pkg::WORDS_PER_PAGE + int'(t.virt_addr[31:22]);
      dir_entry = store_image[dir_word];
      if (dir_entry[0]) begin
         tab_frame = dir_entry[31:12];
         if (tab_frame >= STORE_PAGES) begin
            outcome.status = tlpt_pkg::STAT_OUTSIDE;
            return outcome;
         end
      end else if (t.command == tlpt_pkg::CMD_UNMAP) begin
         outcome.status = tlpt_pkg::STAT_NOT_MAPPED;
         return outcome;
      end else begin
         if (alloc_next >= STORE_PAGES) begin
            outcome.status = tlpt_pkg::STAT_NO_FRAME;
            return outcome;
         end
         // The new table page is not cleared; it keeps whatever it held.
         tab_frame = alloc_next;
         alloc_next = alloc_next + 20'd1;
         store_image[dir_word] = {tab_frame, 12'h000} | flags;
         fresh_table = 1'b1;
      end

      tab_word = int'(tab_frame) * tlpt_pkg::WORDS_PER_PAGE + int'(t.virt_addr[21:12]);
      outcome.table_frame = tab_frame;
      if (t.command == tlpt_pkg::CMD_UNMAP) begin
         store_image[tab_word] = 32'h0;
      end else begin
         store_image[tab_word] = {t.phys_addr[31:12], 12'h000} | flags;
         outcome.read_data = store_image[tab_word];
         outcome.table_allocated = fresh_table;
      end
      return outcome;
   endfunction

   // Directory frames: mostly a few low frames and the last one, sometimes
   // a random frame number, which nearly always lies outside the store.
   function automatic logic [19:0] pick_dir_frame();
      case ($urandom_range(0, 9))
         0: return 20'($urandom);
         1: return 20'd0;
         2: return 20'(STORE_PAGES - 1);
         3: return 20'd128;
         default: return 20'($urandom_range(1, 3));
      endcase
   endfunction

   // Directory indexes come from a small pool so that maps meet existing tables.
   function automatic logic [9:0] pick_dir_idx();
      case ($urandom_range(0, 9))
         0, 1: return 10'($urandom);
         2: return 10'h3FF;
         default: return 10'($urandom_range(0, 5));
      endcase
   endfunction

   function automatic logic [9:0] pick_tab_idx();
      case ($urandom_range(0, 9))
         0, 1, 2: return 10'($urandom);
         3: return 10'h3FF;
         default: return 10'($urandom_range(0, 3));
      endcase
   endfunction

   // A store word that is likely to hold a directory or table entry.
   function automatic logic [17:0] pick_entry_word();
      logic [19:0] frame;
      frame = $urandom_range(0, 1) ? pick_dir_frame() : 20'($urandom_range(0, STORE_PAGES - 1));
      return {frame[7:0], ($urandom_range(0, 1) ? pick_dir_idx() : pick_tab_idx())};
   endfunction

   // Random transaction. Most are well-formed maps and unmaps through a few
   // directories; reads and writes inspect and forge entries, and the rest
   // is unconstrained noise.
   function automatic req_txn_type random_request();
      req_txn_type t;
      int          pick;
      t.command     = tlpt_pkg::cmd_type'($urandom_range(0, 3));
      t.virt_addr   = $urandom;
      t.dir_base    = $urandom;
      t.phys_addr   = $urandom;
      t.user_access = 1'($urandom);
      t.word_addr   = 18'($urandom);
      t.write_data  = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         t.command   = (pick < 40) ? tlpt_pkg::CMD_MAP : tlpt_pkg::CMD_UNMAP;
         t.virt_addr = {pick_dir_idx(), pick_tab_idx(), 12'h000};
         t.dir_base  = {pick_dir_frame(), t.dir_base[11:0]};
         if (t.command == tlpt_pkg::CMD_MAP) t.phys_addr[11:0] = 12'h000;
         // A stray offset now and then tests the alignment check on
         // requests that would otherwise succeed.
         if ($urandom_range(0, 19) == 0) begin
            t.virt_addr[11:0] = 12'($urandom_range(1, 4095));
         end else if ($urandom_range(0, 19) == 0) begin
            t.phys_addr[11:0] = 12'($urandom_range(1, 4095));
         end
      end else if (pick < 72) begin
         t.command   = tlpt_pkg::CMD_READ;
         t.word_addr = pick_entry_word();
      end else if (pick < 84) begin
         t.command   = tlpt_pkg::CMD_WRITE;
         t.word_addr = pick_entry_word();
         // Half of the writes forge an entry, a quarter of those pointing
         // past the store.
         if ($urandom_range(0, 1)) begin
            t.write_data[31:12] = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                            : 20'($urandom_range(0, 255));
         end
      end
      return t;
   endfunction

   // Drives one transaction from a falling edge, waits for the handshake and
   // records the response it owes. It returns at the next falling edge with
   // valid still high, so back-to-back transactions need no second
   // assignment in one time step.
   task automatic issue_request(input req_txn_type t, input bit listed,
                                input tlpt_pkg::rsp_payload_type listed_outcome);
      int                        gap;
      tlpt_pkg::rsp_payload_type predicted;
      gap = idle_span();
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.command     = t.command;
      req_chan.virt_addr   = t.virt_addr;
      req_chan.dir_base    = t.dir_base;
      req_chan.phys_addr   = t.phys_addr;
      req_chan.user_access = t.user_access;
      req_chan.word_addr   = t.word_addr;
      req_chan.write_data  = t.write_data;
      req_chan.valid       = 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      // The predictor runs for listed rows too, to keep the shadow current.
      predicted = page_walk_outcome(t);
      outcomes_due.push_back(listed ? listed_outcome : predicted);
      @(negedge clock);
   endtask

   // Writes the allocator start frame over the APB-style port: a setup
   // cycle, then an access cycle that completes when pready is high.
   task automatic write_first_free(input logic [7:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = tlpt_pkg::CSR_ADDR_W'(int'(tlpt_pkg::REG_FIRST_FREE) * 4);
      pwdata  = {24'h0, value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      alloc_next = {12'h0, value};
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Holds the main sequence at a falling edge until every owed response
   // has arrived. Every transaction yields a response, so the block is idle
   // once the last one has been taken.
   task automatic wait_quiet();
      while (outcomes_due.size() != 0) @(negedge clock);
   endtask

   // Main sequence: reset, the directed table at the reset allocator
   // setting, then one random phase per allocator setting.
   initial begin : stimulus
      logic [7:0] setting;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.command     = tlpt_pkg::CMD_READ;
      req_chan.virt_addr   = '0;
      req_chan.dir_base    = '0;
      req_chan.phys_addr   = '0;
      req_chan.user_access = 1'b0;
      req_chan.word_addr   = '0;
      req_chan.write_data  = '0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The block accepts nothing until its clearing sweep is over; the
      // first transaction simply waits for ready.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         issue_request(DIRECTED_ROWS[i].txn, DIRECTED_ROWS[i].listed, DIRECTED_ROWS[i].outcome);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // The last transaction has been taken; drop valid so that it is
         // not offered a second time while the block drains.
         req_chan.valid = 1'b0;
         wait_quiet();
         setting = (phase == RANDOM_PHASE) ? 8'($urandom_range(2, 253)) : FIRST_FREE_PLAN[phase];
         write_first_free(setting);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Every so often switch into or out of a stretch without idling.
            if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            issue_request(random_request(), 1'b0, '0);
         end
      end

      req_chan.valid = 1'b0;
      steady = 1'b0;
      wait_quiet();
      // A few more cycles catch any response the block should not send.
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fault_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Response side: ready is dropped for random stretches and raised for
   // random windows, changing only at falling edges.
   initial begin : rsp_pacing
      int hold;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      @(negedge clock);
      forever begin
         hold = idle_span();
         if (hold > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // Every response transaction is compared field by field with the oldest
   // owed response.
   always @(posedge clock) begin : rsp_compare
      tlpt_pkg::rsp_payload_type due;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (outcomes_due.size() == 0) begin
            report_fault("response with no request outstanding");
         end else begin
            due = outcomes_due.pop_front();
            if (rsp_chan.status !== due.status)
               report_fault($sformatf("status %0d, predicted %0d", rsp_chan.status, due.status));
            if (rsp_chan.read_data !== due.read_data)
               report_fault($sformatf("read_data %h, predicted %h",
                                      rsp_chan.read_data, due.read_data));
            if (rsp_chan.table_allocated !== due.table_allocated)
               report_fault($sformatf("table_allocated %b, predicted %b",
                                      rsp_chan.table_allocated, due.table_allocated));
            if (rsp_chan.table_frame !== due.table_frame)
               report_fault($sformatf("table_frame %h, predicted %h",
                                      rsp_chan.table_frame, due.table_frame));
         end
      end
   end

   // A hung handshake ends the run here.
   initial begin : watchdog
      #RUN_LIMIT;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hdl/tlpt_pkg.sv
hdl/tlpt_if.sv
hdl/tlpt_store.sv
hdl/tlpt_csr.sv
hdl/tlpt_ctrl.sv
hdl/two_level_page_table_mapper.sv
verif/tb_top.sv
